/* hdl/idfs_pkg.sv */
// ----------------------------------------------------------------------------
// idfs_pkg
// Shared types and constants of the identifier free stack.
// ----------------------------------------------------------------------------
package idfs_pkg;

  localparam int unsigned IdentW     = 10;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned FreeCountW = 11;
  localparam int unsigned MaxIdsDef  = 1024;

  typedef enum logic [FuncW-1:0] {
    FN_REFILL = 2'd0,
    FN_FREE   = 2'd1,
    FN_ALLOC  = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_REFILL,
    S_PUSH,
    S_POP,
    S_POP_WAIT,
    S_RM_RD,
    S_RM_CMP,
    S_MV_RD,
    S_MV_WR,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_CNT,
    ADDR_TOP
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_IDX,
    WD_IDENT,
    WD_RDATA
  } wdata_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_FULL
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       idx_inc;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       mem_we;
    cnt_op_e    cnt_op;
    logic       set_status;
    status_e    status_val;
    logic       got_load;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_end;
    logic fill_last;
    logic match;
    logic out_ready;
  } stat_t;

endpackage

/* hdl/idfs_ram.sv */
// ----------------------------------------------------------------------------
// idfs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module idfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/idfs_ctrl.sv */
// ----------------------------------------------------------------------------
// idfs_ctrl
// Command sequencer of the identifier free stack.
// ----------------------------------------------------------------------------
module idfs_ctrl
  import idfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FuncW-1:0]  func_i,
  output logic              in_stall_o,
  input  stat_t             stat_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  func_e  func;

  assign func = func_e'(func_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel  = ADDR_IDX;
    cmd_o.wdata_sel = WD_IDX;
    cmd_o.cnt_op    = CNT_HOLD;
    cmd_o.status_val = ST_OK;
    in_stall_o     = 1'b1;

    unique case (state_q)
      S_INIT: begin
        // Load entry i with i after reset; no result is produced.
        cmd_o.mem_we  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.cnt_op = CNT_FULL;
          state_d      = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (func)
            FN_REFILL: state_d = S_REFILL;
            FN_FREE:   state_d = S_PUSH;
            FN_ALLOC:  state_d = S_POP;
            FN_REMOVE: begin
              cmd_o.set_status = 1'b1;
              cmd_o.status_val = ST_NOT_FOUND;
              state_d          = S_RM_RD;
            end
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_REFILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.cnt_op = CNT_FULL;
          state_d      = S_RESP;
        end
      end
      S_PUSH: begin
        if (stat_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_FULL;
        end else begin
          cmd_o.addr_sel  = ADDR_CNT;
          cmd_o.wdata_sel = WD_IDENT;
          cmd_o.mem_we    = 1'b1;
          cmd_o.cnt_op    = CNT_INC;
        end
        state_d = S_RESP;
      end
      S_POP: begin
        if (stat_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_EMPTY;
          state_d          = S_RESP;
        end else begin
          cmd_o.addr_sel = ADDR_TOP;
          cmd_o.cnt_op   = CNT_DEC;
          state_d        = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd_o.got_load = 1'b1;
        state_d        = S_RESP;
      end
      S_RM_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_RESP;
        end else begin
          state_d = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_OK;
          state_d          = S_MV_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RM_RD;
        end
      end
      S_MV_RD: begin
        cmd_o.addr_sel = ADDR_TOP;
        cmd_o.cnt_op   = CNT_DEC;
        state_d        = S_MV_WR;
      end
      S_MV_WR: begin
        // The top entry lands in the slot of the match.
        cmd_o.wdata_sel = WD_RDATA;
        cmd_o.mem_we    = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  ast_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cnt_op == CNT_INC) |-> !stat_i.full)
    else $error("push issued on a full stack");
  ast_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cnt_op == CNT_DEC) |-> !stat_i.empty)
    else $error("count decrement on an empty stack");
  ast_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE) && !cmd_o.out_load)
    else $error("result loaded twice for one command");
`endif

endmodule

/* hdl/idfs_dp.sv */
// ----------------------------------------------------------------------------
// idfs_dp
// Datapath of the identifier free stack: stack memory, count, scan index
// and result register.
// ----------------------------------------------------------------------------
module idfs_dp
  import idfs_pkg::*;
#(
  parameter int unsigned MaxIds = MaxIdsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdentW-1:0]     ident_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdentW-1:0]     got_ident_o,
  output logic [StatusW-1:0]    status_o,
  output logic [FreeCountW-1:0] free_count_o
);

  localparam int unsigned AddrW = $clog2(MaxIds);
  localparam int unsigned CntW  = $clog2(MaxIds + 1);

  logic [CntW-1:0]       count_q, idx_q;
  logic [IdentW-1:0]     ident_q, got_q;
  status_e               status_q;
  logic                  out_valid_q;
  logic [IdentW-1:0]     got_out_q;
  logic [StatusW-1:0]    status_out_q;
  logic [FreeCountW-1:0] count_out_q;

  logic [AddrW-1:0]  addr;
  logic [IdentW-1:0] wdata, rdata;
  logic [CntW-1:0]   top;

  assign top = count_q - CntW'(1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CNT: addr = count_q[AddrW-1:0];
      ADDR_TOP: addr = top[AddrW-1:0];
      default:  addr = idx_q[AddrW-1:0];
    endcase
    case (cmd_i.wdata_sel)
      WD_IDENT: wdata = ident_q;
      WD_RDATA: wdata = rdata;
      default:  wdata = IdentW'(idx_q);
    endcase
  end

  idfs_ram #(
    .Width (IdentW),
    .Depth (MaxIds)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CntW'(MaxIds);
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.cnt_op)
        CNT_INC:  count_q <= count_q + CntW'(1);
        CNT_DEC:  count_q <= top;
        CNT_FULL: count_q <= CntW'(MaxIds);
        default:  count_q <= count_q;
      endcase
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ident_q  <= ident_i;
      got_q    <= '0;
      status_q <= ST_OK;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_val;
    end
    if (cmd_i.got_load) begin
      got_q <= rdata;
    end
    if (cmd_i.out_load) begin
      got_out_q    <= got_q;
      status_out_q <= status_q;
      count_out_q  <= FreeCountW'(count_q);
    end
  end

  assign stat_o.full      = (count_q == CntW'(MaxIds));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.idx_end   = (idx_q >= count_q);
  assign stat_o.fill_last = (idx_q == CntW'(MaxIds - 1));
  assign stat_o.match     = (rdata == ident_q);
  assign stat_o.out_ready = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign got_ident_o  = got_out_q;
  assign status_o     = status_out_q;
  assign free_count_o = count_out_q;

`ifndef SYNTHESIS
  ast_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxIds))
    else $error("free count beyond pool size");
  ast_empty_no_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_o == ST_EMPTY)) |-> (got_ident_o == '0))
    else $error("failed allocate reports an identifier");
  ast_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

/* hdl/identifier_free_stack.sv */
// ----------------------------------------------------------------------------
// identifier_free_stack
// Allocator of node identifiers kept as a stack of free identifiers.
// ----------------------------------------------------------------------------
// Commands are taken one at a time and each returns exactly one result.
// An allocate waits for one stack memory read with registered data (none
// on an empty stack), a refill does one memory write per identifier, and
// a remove reads and compares the free entries one at a time through the
// single memory port until one matches or none is left. After reset the
// block loads the stack with identifiers 0 to MAX_IDS-1 and stalls its
// input meanwhile. A finished result waits in an output register; a
// stalled output holds back only the next command's result.
module identifier_free_stack
  import idfs_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FuncW-1:0]      func_i,
  input  logic [IdentW-1:0]     ident_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdentW-1:0]     got_ident_o,
  output logic [StatusW-1:0]    status_o,
  output logic [FreeCountW-1:0] free_count_o
);

  cmd_t  cmd;
  stat_t stat;

  idfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  idfs_dp #(
    .MaxIds (MAX_IDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ident_i      (ident_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .got_ident_o  (got_ident_o),
    .status_o     (status_o),
    .free_count_o (free_count_o)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the identifier free stack. A directed sequence
// walks full, duplicate and missing-identifier cases first, then random
// commands follow under three patterns of sender and receiver idling.
// Each result is checked against a known directed value or a behavioral model.
// ----------------------------------------------------------------------------
module tb;
  import idfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime     ClkPeriod     = 12ns;
  localparam int unsigned MaxIds        = MaxIdsDef;
  localparam int unsigned LowWater      = 48;
  localparam int unsigned PhaseItems    = 643;
  localparam int unsigned DrainCycles   = 2 * MaxIds + 16;
  localparam real         TimeoutCycles = 12.0e6;

  typedef struct packed {
    logic [IdentW-1:0]     got;
    status_e               status;
    logic [FreeCountW-1:0] count;
  } cmd_result_t;

  typedef struct {
    func_e             func;
    logic [IdentW-1:0] ident;
    bit                known;
    cmd_result_t       want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FuncW-1:0]      func_i;
  logic [IdentW-1:0]     ident_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [IdentW-1:0]     got_ident_o;
  logic [StatusW-1:0]    status_o;
  logic [FreeCountW-1:0] free_count_o;

  // Behavioral copy of the free stack.
  logic [IdentW-1:0] free_ids [MaxIds];
  int unsigned       free_total;
  logic [IdentW-1:0] handed_out_q [$];

  cmd_result_t       pending_results [$];
  dir_row_t          dir_rows [$];
  int unsigned       mismatches   = 0;
  int unsigned       results_seen = 0;
  int unsigned       snd_idle_pct = 18;
  int unsigned       rcv_idle_pct = 58;

  identifier_free_stack #(
    .MAX_IDS(MaxIds)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .ident_i     (ident_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .got_ident_o (got_ident_o),
    .status_o    (status_o),
    .free_count_o(free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic void refill_model();
    for (int unsigned k = 0; k < MaxIds; k++) begin
      free_ids[k] = k[IdentW-1:0];
    end
    free_total = MaxIds;
    handed_out_q.delete();
  endfunction

  // Applies one command to the model and returns the result it produces.
  function automatic cmd_result_t apply_command(func_e func, logic [IdentW-1:0] ident);
    cmd_result_t res;
    res.got    = '0;
    res.status = ST_OK;
    case (func)
      FN_REFILL: begin
        refill_model();
      end
      FN_FREE: begin
        if (free_total >= MaxIds) begin
          res.status = ST_FULL;
        end else begin
          free_ids[free_total] = ident;
          free_total++;
        end
      end
      FN_ALLOC: begin
        if (free_total == 0) begin
          res.status = ST_EMPTY;
        end else begin
          free_total--;
          res.got = free_ids[free_total];
          handed_out_q.push_back(res.got);
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
        for (int unsigned k = 0; k < free_total; k++) begin
          if (free_ids[k] == ident) begin
            free_total--;
            free_ids[k] = free_ids[free_total];
            res.status  = ST_OK;
            handed_out_q.push_back(ident);
            break;
          end
        end
      end
    endcase
    res.count = free_total[FreeCountW-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned seen,
                               input int unsigned want);
    mismatches++;
    $display("%0t: result %0d, %s: got %0d, expected %0d",
             $realtime, results_seen, what, seen, want);
  endtask

  function automatic void add_row(func_e func, logic [IdentW-1:0] ident, bit known,
                                  logic [IdentW-1:0] got, status_e status,
                                  logic [FreeCountW-1:0] count);
    dir_row_t row;
    row.func        = func;
    row.ident       = ident;
    row.known       = known;
    row.want.got    = got;
    row.want.status = status;
    row.want.count  = count;
    dir_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input func_e func, input logic [IdentW-1:0] ident,
                          input bit known, input cmd_result_t want);
    cmd_result_t res;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    ident_i    <= ident;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = apply_command(func, ident);
    pending_results.push_back(known ? want : res);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_items);
    func_e             func;
    logic [IdentW-1:0] ident;
    int unsigned       roll;
    int unsigned       pick;
    cmd_result_t       none;
    none = '0;
    repeat (n_items) begin
      roll  = $urandom_range(999);
      ident = IdentW'($urandom_range(MaxIds - 1));
      // Above the low-water mark the mix drains the stack so that removes stay
      // short; below it the stack wanders around empty.
      if (free_total >= LowWater) begin
        if (roll < 900) func = FN_ALLOC;
        else if (roll < 960) func = FN_REMOVE;
        else func = FN_FREE;
      end else if (roll < 2) begin
        func = FN_REFILL;
      end else if (roll < 400) begin
        func = FN_ALLOC;
      end else if (roll < 750) begin
        func = FN_FREE;
      end else begin
        func = FN_REMOVE;
      end
      if (func == FN_FREE && handed_out_q.size() != 0 && $urandom_range(9) < 7) begin
        pick  = $urandom_range(handed_out_q.size() - 1);
        ident = handed_out_q[pick];
        handed_out_q.delete(pick);
      end else if (func == FN_REMOVE && free_total != 0 && $urandom_range(9) < 7) begin
        ident = free_ids[$urandom_range(free_total - 1)];
      end
      send_cmd(func, ident, 1'b0, none);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cmd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("transfer with no command pending", free_count_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (got_ident_o !== want.got) begin
          flag_mismatch("got_ident", got_ident_o, want.got);
        end
        if (status_o !== want.status) begin
          flag_mismatch("status", status_o, want.status);
        end
        if (free_count_o !== want.count) begin
          flag_mismatch("free_count", free_count_o, want.count);
        end
      end
      results_seen++;
    end
  end

  initial begin
    in_valid_i = 1'b0;
    func_i     = FN_REFILL;
    ident_i    = '0;
    rst_ni     = 1'b0;
    refill_model();

    // After reset the stack holds 0..1023 with 1023 on top.
    add_row(FN_FREE,   10'd0,    1'b1, 10'd0,    ST_FULL,      11'd1024);
    add_row(FN_FREE,   10'd1023, 1'b1, 10'd0,    ST_FULL,      11'd1024);
    add_row(FN_ALLOC,  10'd0,    1'b1, 10'd1023, ST_OK,        11'd1023);
    add_row(FN_ALLOC,  10'd0,    1'b1, 10'd1022, ST_OK,        11'd1022);
    add_row(FN_REMOVE, 10'd0,    1'b1, 10'd0,    ST_OK,        11'd1021);
    add_row(FN_REMOVE, 10'd1023, 1'b1, 10'd0,    ST_NOT_FOUND, 11'd1021);
    add_row(FN_FREE,   10'd1023, 1'b1, 10'd0,    ST_OK,        11'd1022);
    // Freeing the same identifier twice leaves two copies on the stack.
    add_row(FN_FREE,   10'd1023, 1'b1, 10'd0,    ST_OK,        11'd1023);
    add_row(FN_FREE,   10'd0,    1'b1, 10'd0,    ST_OK,        11'd1024);
    add_row(FN_FREE,   10'd5,    1'b1, 10'd0,    ST_FULL,      11'd1024);
    add_row(FN_REMOVE, 10'd1023, 1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_ALLOC,  10'd0,    1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_REMOVE, 10'd1021, 1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_REFILL, 10'd1023, 1'b1, 10'd0,    ST_OK,        11'd1024);
    add_row(FN_ALLOC,  10'd0,    1'b1, 10'd1023, ST_OK,        11'd1023);
    add_row(FN_REMOVE, 10'd1023, 1'b1, 10'd0,    ST_NOT_FOUND, 11'd1023);
    add_row(FN_REMOVE, 10'd1022, 1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_REFILL, 10'd0,    1'b1, 10'd0,    ST_OK,        11'd1024);
    add_row(FN_REMOVE, 10'd512,  1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_REMOVE, 10'd341,  1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_REMOVE, 10'd682,  1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_ALLOC,  10'd0,    1'b0, 10'd0,    ST_OK,        11'd0);
    add_row(FN_FREE,   10'd682,  1'b0, 10'd0,    ST_OK,        11'd0);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].func, dir_rows[i].ident, dir_rows[i].known, dir_rows[i].want);
    end

    run_random(PhaseItems);
    snd_idle_pct = 58;
    rcv_idle_pct = 18;
    run_random(PhaseItems);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(PhaseItems);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** identifier_free_stack: PASSED **");
    end else begin
      $display("** identifier_free_stack: FAILED **");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** identifier_free_stack: FAILED **");
    $finish;
  end

endmodule
